>>> sv/hrc_pkg.sv
package hrc_pkg;

  // Request codes on the event channel
  typedef enum logic [2:0] {
    FUNC_TICK         = 3'd0,
    FUNC_START_INVITE = 3'd1,
    FUNC_START_ACCEPT = 3'd2,
    FUNC_GOT_ACCEPT   = 3'd3,
    FUNC_GOT_ACK      = 3'd4,
    FUNC_GOT_DECLINE  = 3'd5,
    FUNC_CANCEL_INV   = 3'd6,
    FUNC_CLEAR_ALL    = 3'd7
  } func_t;

  // Action codes on the result channel
  typedef enum logic [2:0] {
    ACT_SEND_INVITE     = 3'd0,
    ACT_SEND_ACCEPT     = 3'd1,
    ACT_SEND_ACK        = 3'd2,
    ACT_ACCEPT_REPORTED = 3'd3,
    ACT_INVITE_FAILED   = 3'd4
  } action_t;

  // Register select, taken from paddr[2]
  localparam logic REG_RETRY_INTERVAL = 1'b0;
  localparam logic REG_RETRY_LIMIT    = 1'b1;

  localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd350;
  localparam logic [7:0]  RETRY_LIMIT_RESET    = 8'd14;

  typedef struct packed {
    func_t       func;
    logic [31:0] peer_address;
    logic [31:0] now_ms;
  } evt_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] target_address;
    logic        last;
  } res_t;

endpackage

>>> sv/handshake_retransmit_controller_top.sv
// Retransmit controller for one outgoing invite and one outgoing accept. Each
// accepted event request is decoded combinationally against the handshake
// state into zero, one or two result requests, written into a two-entry
// result queue together with the state update. A new event is taken whenever
// the queue is empty, or holds one result that leaves in the same cycle, so
// events that give one result (or none) run at one per cycle while res_stall
// is low; after a two-result event the next waits until its second result is
// leaving. Results carry last=1 on the final result of their event. Retry
// interval and limit registers sit at APB byte addresses 0 and 4; the user
// must write them only while the block is idle, the block does not enforce it.
module handshake_retransmit_controller_top (
  input  logic               clk,
  input  logic               rst,
  // event channel
  input  logic               evt_valid,
  output logic               evt_stall,
  input  hrc_pkg::evt_t      evt_data,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output hrc_pkg::res_t      res_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [15:0] retry_interval_ms;
  logic [7:0]  retry_limit;

  // handshake state
  logic        invite_pending, invite_pending_next;
  logic [31:0] invite_peer,    invite_peer_next;
  logic [31:0] invite_due,     invite_due_next;
  logic [7:0]  invite_tries,   invite_tries_next;
  logic        accept_pending, accept_pending_next;
  logic [31:0] accept_peer,    accept_peer_next;
  logic [31:0] accept_due,     accept_due_next;
  logic [7:0]  accept_tries,   accept_tries_next;
  logic        accepted_seen,  accepted_seen_next;
  logic [31:0] accepted_peer,  accepted_peer_next;

  // result queue
  hrc_pkg::res_t q0, q0_next;
  hrc_pkg::res_t q1, q1_next;
  logic [1:0]    count, count_next;

  logic          evt_fire;
  logic          res_pop;
  logic          cfg_write;
  logic [31:0]   due_next;
  logic          inv_due_hit;
  logic          acc_due_hit;

  hrc_pkg::res_t r0, r1;
  logic [1:0]    n;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign res_valid = (count != 2'd0);
  assign res_data  = q0;
  assign res_pop   = res_valid && !res_stall;
  assign evt_stall = !((count == 2'd0) || ((count == 2'd1) && res_pop));
  assign evt_fire  = evt_valid && !evt_stall;

  assign due_next    = evt_data.now_ms + {16'd0, retry_interval_ms};
  assign inv_due_hit = invite_pending && (evt_data.now_ms >= invite_due);
  assign acc_due_hit = accept_pending && (evt_data.now_ms >= accept_due);

  // register readback
  always_comb begin
    unique case (paddr[2])
      hrc_pkg::REG_RETRY_INTERVAL: prdata = {16'd0, retry_interval_ms};
      hrc_pkg::REG_RETRY_LIMIT:    prdata = {24'd0, retry_limit};
      default:                     prdata = 32'd0;
    endcase
  end

  // decode one event: next state and up to two results
  always_comb begin
    invite_pending_next = invite_pending;
    invite_peer_next    = invite_peer;
    invite_due_next     = invite_due;
    invite_tries_next   = invite_tries;
    accept_pending_next = accept_pending;
    accept_peer_next    = accept_peer;
    accept_due_next     = accept_due;
    accept_tries_next   = accept_tries;
    accepted_seen_next  = accepted_seen;
    accepted_peer_next  = accepted_peer;
    r0 = '{action: hrc_pkg::ACT_SEND_INVITE, target_address: evt_data.peer_address,
           last: 1'b0};
    r1 = r0;
    n  = 2'd0;

    unique case (evt_data.func)
      hrc_pkg::FUNC_TICK: begin
        // invite first, then accept
        if (inv_due_hit) begin
          r0.target_address = invite_peer;
          n = 2'd1;
          if (invite_tries >= retry_limit) begin
            invite_pending_next = 1'b0;
            r0.action = hrc_pkg::ACT_INVITE_FAILED;
          end else begin
            r0.action = hrc_pkg::ACT_SEND_INVITE;
            invite_tries_next = invite_tries + 8'd1;
            invite_due_next   = due_next;
          end
        end
        if (acc_due_hit) begin
          if (accept_tries >= retry_limit) begin
            accept_pending_next = 1'b0;
          end else begin
            accept_tries_next = accept_tries + 8'd1;
            accept_due_next   = due_next;
            if (inv_due_hit) begin
              r1.action         = hrc_pkg::ACT_SEND_ACCEPT;
              r1.target_address = accept_peer;
              n = 2'd2;
            end else begin
              r0.action         = hrc_pkg::ACT_SEND_ACCEPT;
              r0.target_address = accept_peer;
              n = 2'd1;
            end
          end
        end
      end
      hrc_pkg::FUNC_START_INVITE: begin
        invite_pending_next = 1'b1;
        invite_peer_next    = evt_data.peer_address;
        invite_due_next     = due_next;
        invite_tries_next   = 8'd0;
        accepted_seen_next  = 1'b0;
        r0.action = hrc_pkg::ACT_SEND_INVITE;
        n = 2'd1;
      end
      hrc_pkg::FUNC_START_ACCEPT: begin
        accept_pending_next = 1'b1;
        accept_peer_next    = evt_data.peer_address;
        accept_due_next     = due_next;
        accept_tries_next   = 8'd0;
        r0.action = hrc_pkg::ACT_SEND_ACCEPT;
        n = 2'd1;
      end
      hrc_pkg::FUNC_GOT_ACCEPT: begin
        // always ack; do not report the last reported peer again
        r0.action = hrc_pkg::ACT_SEND_ACK;
        n = 2'd1;
        if (invite_pending && (invite_peer == evt_data.peer_address)) begin
          invite_pending_next = 1'b0;
        end
        if (!(accepted_seen && (accepted_peer == evt_data.peer_address))) begin
          accepted_seen_next = 1'b1;
          accepted_peer_next = evt_data.peer_address;
          r1.action = hrc_pkg::ACT_ACCEPT_REPORTED;
          n = 2'd2;
        end
      end
      hrc_pkg::FUNC_GOT_ACK: begin
        if (accept_pending && (accept_peer == evt_data.peer_address)) begin
          accept_pending_next = 1'b0;
        end
      end
      hrc_pkg::FUNC_GOT_DECLINE: begin
        if (invite_pending && (invite_peer == evt_data.peer_address)) begin
          invite_pending_next = 1'b0;
          r0.action = hrc_pkg::ACT_INVITE_FAILED;
          n = 2'd1;
        end
      end
      hrc_pkg::FUNC_CANCEL_INV: begin
        invite_pending_next = 1'b0;
      end
      hrc_pkg::FUNC_CLEAR_ALL: begin
        invite_pending_next = 1'b0;
        accept_pending_next = 1'b0;
        accepted_seen_next  = 1'b0;
      end
      default: begin
        invite_pending_next = invite_pending;
      end
    endcase

    // mark the final result of the event
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  // advance the result queue: pop the head, then load a new event's results
  always_comb begin
    q0_next    = q0;
    q1_next    = q1;
    count_next = count;
    if (res_pop) begin
      q0_next    = q1;
      count_next = count - 2'd1;
    end
    if (evt_fire) begin
      q0_next    = r0;
      q1_next    = r1;
      count_next = n;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval_ms <= hrc_pkg::RETRY_INTERVAL_RESET;
      retry_limit       <= hrc_pkg::RETRY_LIMIT_RESET;
      invite_pending    <= 1'b0;
      accept_pending    <= 1'b0;
      accepted_seen     <= 1'b0;
      count             <= 2'd0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          hrc_pkg::REG_RETRY_INTERVAL: retry_interval_ms <= pwdata[15:0];
          hrc_pkg::REG_RETRY_LIMIT:    retry_limit       <= pwdata[7:0];
          default:                     retry_limit       <= retry_limit;
        endcase
      end
      if (evt_fire) begin
        invite_pending <= invite_pending_next;
        accept_pending <= accept_pending_next;
        accepted_seen  <= accepted_seen_next;
      end
      count <= count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (evt_fire) begin
      invite_peer   <= invite_peer_next;
      invite_due    <= invite_due_next;
      invite_tries  <= invite_tries_next;
      accept_peer   <= accept_peer_next;
      accept_due    <= accept_due_next;
      accept_tries  <= accept_tries_next;
      accepted_peer <= accepted_peer_next;
    end
    q0 <= q0_next;
    q1 <= q1_next;
  end

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");

  // a single queued result always closes its event
  assert property (@(posedge clk) disable iff (rst) (count == 2'd1) |-> q0.last)
    else $error("lone queued result lacks last");

  // a full queue holds exactly one event's pair
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> (!q0.last && q1.last))
    else $error("queued pair has wrong last marks");

  // starting an invite leaves it pending
  assert property (@(posedge clk) disable iff (rst)
    (evt_fire && (evt_data.func == hrc_pkg::FUNC_START_INVITE)) |=> invite_pending)
    else $error("invite not pending after start");

  // clear all drops every handshake
  assert property (@(posedge clk) disable iff (rst)
    (evt_fire && (evt_data.func == hrc_pkg::FUNC_CLEAR_ALL))
    |=> (!invite_pending && !accept_pending && !accepted_seen))
    else $error("state left after clear all");

endmodule

>>> bench/handshake_retransmit_controller_top_tb.sv
`timescale 1ns / 1ps

module handshake_retransmit_controller_top_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic          clk;
  logic          rst = 1'b1;
  logic          evt_valid = 1'b0;
  logic          evt_stall;
  hrc_pkg::evt_t evt_data = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  hrc_pkg::res_t res_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Shadow of the block's registers and handshake state
  logic [15:0] cfg_interval = hrc_pkg::RETRY_INTERVAL_RESET;
  logic [7:0]  cfg_limit = hrc_pkg::RETRY_LIMIT_RESET;
  logic        inv_pend = 1'b0;
  logic [31:0] inv_peer = '0;
  logic [31:0] inv_due = '0;
  logic [7:0]  inv_tries = '0;
  logic        acc_pend = 1'b0;
  logic [31:0] acc_peer = '0;
  logic [31:0] acc_due = '0;
  logic [7:0]  acc_tries = '0;
  logic        rpt_seen = 1'b0;
  logic [31:0] rpt_peer = '0;

  hrc_pkg::res_t handshake_actions[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   events_sent = 0;
  logic          steady_run = 1'b0;
  logic [31:0]   clock_ms = '0;
  logic [31:0]   peer_pool[4];

  handshake_retransmit_controller_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stall the result side at random, except during the steady stretch
  always @(posedge clk) begin
    res_stall <= !steady_run && ($urandom_range(99) < 24);
  end

  // Compare each accepted result request with the oldest predicted action
  always @(posedge clk) begin : check_results
    hrc_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (handshake_actions.size() == 0) begin
        $error("unexpected result: action %0d, target %h, last %0b",
               res_data.action, res_data.target_address, res_data.last);
        mismatch_count++;
      end else begin
        want = handshake_actions.pop_front();
        if (res_data.action !== want.action) begin
          $error("action: expected %0d, actual %0d", want.action, res_data.action);
          mismatch_count++;
        end
        if (res_data.target_address !== want.target_address) begin
          $error("target_address: expected %h, actual %h",
                 want.target_address, res_data.target_address);
          mismatch_count++;
        end
        if (res_data.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, res_data.last);
          mismatch_count++;
        end
      end
    end
  end

  function automatic hrc_pkg::res_t action_for(hrc_pkg::action_t act, logic [31:0] addr);
    hrc_pkg::res_t r;
    r.action = act;
    r.target_address = addr;
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the handshake state by one event and queue the actions it causes
  task automatic apply_handshake_event(input hrc_pkg::evt_t ev);
    logic [31:0] next_due;
    hrc_pkg::res_t batch[$];
    next_due = ev.now_ms + {16'd0, cfg_interval};
    case (ev.func)
      hrc_pkg::FUNC_TICK: begin
        if (inv_pend && ev.now_ms >= inv_due) begin
          if (inv_tries >= cfg_limit) begin
            inv_pend = 1'b0;
            batch.push_back(action_for(hrc_pkg::ACT_INVITE_FAILED, inv_peer));
          end else begin
            batch.push_back(action_for(hrc_pkg::ACT_SEND_INVITE, inv_peer));
            inv_tries = inv_tries + 8'd1;
            inv_due = next_due;
          end
        end
        // Giving up on the accept is silent
        if (acc_pend && ev.now_ms >= acc_due) begin
          if (acc_tries >= cfg_limit) begin
            acc_pend = 1'b0;
          end else begin
            batch.push_back(action_for(hrc_pkg::ACT_SEND_ACCEPT, acc_peer));
            acc_tries = acc_tries + 8'd1;
            acc_due = next_due;
          end
        end
      end
      hrc_pkg::FUNC_START_INVITE: begin
        inv_pend = 1'b1;
        inv_peer = ev.peer_address;
        inv_due = next_due;
        inv_tries = '0;
        rpt_seen = 1'b0;
        batch.push_back(action_for(hrc_pkg::ACT_SEND_INVITE, ev.peer_address));
      end
      hrc_pkg::FUNC_START_ACCEPT: begin
        acc_pend = 1'b1;
        acc_peer = ev.peer_address;
        acc_due = next_due;
        acc_tries = '0;
        batch.push_back(action_for(hrc_pkg::ACT_SEND_ACCEPT, ev.peer_address));
      end
      hrc_pkg::FUNC_GOT_ACCEPT: begin
        batch.push_back(action_for(hrc_pkg::ACT_SEND_ACK, ev.peer_address));
        if (inv_pend && inv_peer == ev.peer_address) inv_pend = 1'b0;
        if (!(rpt_seen && rpt_peer == ev.peer_address)) begin
          rpt_seen = 1'b1;
          rpt_peer = ev.peer_address;
          batch.push_back(action_for(hrc_pkg::ACT_ACCEPT_REPORTED, ev.peer_address));
        end
      end
      hrc_pkg::FUNC_GOT_ACK: begin
        if (acc_pend && acc_peer == ev.peer_address) acc_pend = 1'b0;
      end
      hrc_pkg::FUNC_GOT_DECLINE: begin
        if (inv_pend && inv_peer == ev.peer_address) begin
          inv_pend = 1'b0;
          batch.push_back(action_for(hrc_pkg::ACT_INVITE_FAILED, ev.peer_address));
        end
      end
      hrc_pkg::FUNC_CANCEL_INV: begin
        inv_pend = 1'b0;
      end
      hrc_pkg::FUNC_CLEAR_ALL: begin
        inv_pend = 1'b0;
        acc_pend = 1'b0;
        rpt_seen = 1'b0;
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) handshake_actions.push_back(batch[i]);
  endtask

  // Offer one event request, with random idle cycles ahead of it
  task automatic send_event(input hrc_pkg::func_t f, input logic [31:0] peer,
                            input logic [31:0] now);
    hrc_pkg::evt_t ev;
    ev.func = f;
    ev.peer_address = peer;
    ev.now_ms = now;
    while (!steady_run && $urandom_range(99) < 24) begin
      evt_valid <= 1'b0;
      @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt_data <= ev;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    apply_handshake_event(ev);
    events_sent++;
  endtask

  // Drop valid and wait until every predicted action has come out
  task automatic settle_block();
    evt_valid <= 1'b0;
    while (handshake_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == hrc_pkg::REG_RETRY_INTERVAL) cfg_interval = value[15:0];
    else cfg_limit = value[7:0];
    @(posedge clk);
  endtask

  // Invite retransmit on the due time and decline from the right and wrong peer
  task automatic test_invite_retry();
    send_event(hrc_pkg::FUNC_START_INVITE, 32'h1234_5678, 32'd1000);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'd1349);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'd1350);
    send_event(hrc_pkg::FUNC_GOT_DECLINE, 32'hFFFF_FFFF, 32'd1400);
    send_event(hrc_pkg::FUNC_GOT_DECLINE, 32'h1234_5678, 32'd1400);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'd5000);
  endtask

  // Accept retransmit, ack matching, and one report per peer
  task automatic test_accept_paths();
    send_event(hrc_pkg::FUNC_START_ACCEPT, 32'hFFFF_FFFF, 32'd0);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'd350);
    send_event(hrc_pkg::FUNC_GOT_ACK, 32'h1234_5678, 32'd360);
    send_event(hrc_pkg::FUNC_GOT_ACK, 32'hFFFF_FFFF, 32'd370);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'd2000);
    send_event(hrc_pkg::FUNC_GOT_ACCEPT, 32'h0, 32'd2000);
    send_event(hrc_pkg::FUNC_GOT_ACCEPT, 32'h0, 32'd2000);
    send_event(hrc_pkg::FUNC_START_INVITE, 32'h0, 32'd2000);
    send_event(hrc_pkg::FUNC_GOT_ACCEPT, 32'h0, 32'd2100);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'd9000);
  endtask

  // Zero interval with zero limit, then the largest interval with a wrapped due time
  task automatic test_register_extremes();
    settle_block();
    write_reg(hrc_pkg::REG_RETRY_INTERVAL, 32'h0);
    write_reg(hrc_pkg::REG_RETRY_LIMIT, 32'h0);
    send_event(hrc_pkg::FUNC_START_INVITE, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
    send_event(hrc_pkg::FUNC_START_ACCEPT, 32'h5A5A_A5A5, 32'hFFFF_FFFF);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'hFFFF_FFFF);
    settle_block();
    write_reg(hrc_pkg::REG_RETRY_INTERVAL, 32'hFFFF_FFFF);
    write_reg(hrc_pkg::REG_RETRY_LIMIT, 32'hFFFF_FFFF);
    send_event(hrc_pkg::FUNC_START_INVITE, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
    send_event(hrc_pkg::FUNC_START_ACCEPT, 32'h5A5A_A5A5, 32'h0);
    send_event(hrc_pkg::FUNC_TICK, 32'hFFFF_FFFF, 32'd65535);
  endtask

  // Cancel and clear leave nothing pending
  task automatic test_cancel_and_clear();
    send_event(hrc_pkg::FUNC_CANCEL_INV, 32'hFFFF_FFFF, 32'd70000);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'd200000);
    send_event(hrc_pkg::FUNC_CLEAR_ALL, 32'h0, 32'd200000);
    send_event(hrc_pkg::FUNC_TICK, 32'h0, 32'hFFFF_FFFF);
    send_event(hrc_pkg::FUNC_GOT_DECLINE, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
  endtask

  // Handshake sessions with random content, a fresh setting per phase
  task automatic test_random_sessions(input int unsigned event_goal);
    int unsigned phase;
    int unsigned phase_end;
    int unsigned kind;
    int unsigned ticks;
    logic [15:0] ival;
    logic [7:0]  lim;
    logic [31:0] p;
    logic [31:0] other;
    phase = 0;
    while (events_sent < event_goal) begin
      settle_block();
      case (phase % 6)
        0: begin ival = 16'($urandom_range(400, 20)); lim = 8'd3; end
        1: begin ival = 16'd0; lim = 8'($urandom_range(2)); end
        2: begin ival = 16'($urandom_range(100, 1)); lim = 8'($urandom_range(5, 1)); end
        3: begin ival = 16'hFFFF; lim = 8'd2; end
        4: begin ival = 16'($urandom_range(65535, 1)); lim = 8'($urandom_range(6)); end
        default: begin ival = 16'd1; lim = 8'hFF; end
      endcase
      write_reg(hrc_pkg::REG_RETRY_INTERVAL,
                ($urandom() & 32'hFFFF_0000) | {16'd0, ival});
      write_reg(hrc_pkg::REG_RETRY_LIMIT,
                ($urandom() & 32'hFFFF_FF00) | {24'd0, lim});
      steady_run = (phase == 2);
      peer_pool[0] = $urandom();
      peer_pool[1] = $urandom();
      peer_pool[2] = ~peer_pool[0];
      peer_pool[3] = peer_pool[0] ^ 32'h1;
      if ($urandom_range(3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(200000);
      phase_end = events_sent + 150;
      while (events_sent < phase_end && events_sent < event_goal) begin
        p = peer_pool[$urandom_range(3)];
        other = peer_pool[$urandom_range(3)];
        kind = $urandom_range(99);
        if (kind < 15) begin
          // noise: any event with any fields
          send_event(hrc_pkg::func_t'($urandom_range(7)), $urandom(), $urandom());
        end else begin
          if (kind < 55) begin
            send_event(hrc_pkg::FUNC_START_INVITE, p, clock_ms);
          end else if (kind < 85) begin
            send_event(hrc_pkg::FUNC_START_ACCEPT, p, clock_ms);
          end else begin
            send_event(hrc_pkg::FUNC_START_INVITE, p, clock_ms);
            send_event(hrc_pkg::FUNC_START_ACCEPT, other, clock_ms);
          end
          // ticks around the retry interval, up to two past a limit below 6, else up to 8
          ticks = $urandom_range((cfg_limit < 6) ? cfg_limit + 2 : 8);
          repeat (ticks) begin
            case ($urandom_range(3))
              0: clock_ms = clock_ms + cfg_interval - (cfg_interval != 0);
              1: clock_ms = clock_ms + cfg_interval;
              2: clock_ms = clock_ms + cfg_interval + $urandom_range(40);
              default: clock_ms = clock_ms + $urandom_range(cfg_interval);
            endcase
            send_event(hrc_pkg::FUNC_TICK, $urandom(), clock_ms);
          end
          // close the session, or leave it pending
          case ($urandom_range(7))
            0: send_event(hrc_pkg::FUNC_GOT_ACCEPT, p, clock_ms);
            1: send_event(hrc_pkg::FUNC_GOT_ACCEPT, other, clock_ms);
            2: send_event(hrc_pkg::FUNC_GOT_ACK, p, clock_ms);
            3: send_event(hrc_pkg::FUNC_GOT_DECLINE, p, clock_ms);
            4: send_event(hrc_pkg::FUNC_GOT_DECLINE, other, clock_ms);
            5: send_event(hrc_pkg::FUNC_CANCEL_INV, p, clock_ms);
            6: send_event(hrc_pkg::FUNC_CLEAR_ALL, p, clock_ms);
            default: ;
          endcase
        end
      end
      phase++;
    end
    steady_run = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_invite_retry();
    test_accept_paths();
    test_register_extremes();
    test_cancel_and_clear();
    test_random_sessions(880);
    settle_block();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
